/* src/xagtc_pkg.sv */
// ----------------------------------------------------------------------------
// xagtc_pkg
// Shared constants, types and helpers for the XOR/AND graph truth table check.
// ----------------------------------------------------------------------------
package xagtc_pkg;

	localparam int MAX_VERTICES  = 64;
	localparam int NUM_VARIABLES = 5;

	// truth table rows, vertex index width, vertex count width
	localparam int ROWS    = 2 ** NUM_VARIABLES;
	localparam int VIDX_W  = $clog2(MAX_VERTICES);
	localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
	localparam int CODE_W  = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = ROWS;

	// bit positions inside an operand code
	localparam int CODE_INV_BIT  = 0;
	localparam int CODE_KIND_BIT = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TABLE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_INVERT = 1'b1;

	typedef enum logic {
		GATE_AND = 1'b0,
		GATE_XOR = 1'b1
	} gate_kind_t;

	// control of one gate, from the accept stage to evaluation
	typedef struct packed {
		logic [VIDX_W-1:0] first_src;
		logic [VIDX_W-1:0] second_src;
		logic              first_inv;
		logic              second_inv;
		logic              first_var;   // operand is a primary variable
		logic              second_var;
		gate_kind_t        kind;
		logic              zero;        // bad source or mixed kind: table forced to 0
		logic              err;         // circuit error including this gate
		logic              wr_en;       // room left in the vertex store
		logic              last;
	} gate_ctl_t;

	// table of a primary variable: row r holds bit idx of r
	function automatic logic [ROWS-1:0] var_table(input logic [VIDX_W-1:0] idx);
		logic [ROWS-1:0]          t;
		logic [NUM_VARIABLES-1:0] rb;
		t = '0;
		for (int r = 0; r < ROWS; r++) begin
			rb = NUM_VARIABLES'(r);
			for (int v = 0; v < NUM_VARIABLES; v++) begin
				if (idx == VIDX_W'(v)) begin
					t[r] = rb[v];
				end
			end
		end
		return t;
	endfunction

endpackage

/* src/xor_and_graph_truth_table_check.sv */
// ----------------------------------------------------------------------------
// xor_and_graph_truth_table_check
// Builds a five-input XOR/AND gate graph one gate per item and checks the
// last gate's table, optionally inverted, against a target truth table.
// ----------------------------------------------------------------------------
// One gate is accepted each cycle unless in_stall is high. A gate is checked
// and its vertex slot assigned in the cycle it is accepted; its two operand
// tables are read from the 64 x 32-bit vertex register file at that edge,
// with write-through from the gate ahead, and the table is evaluated in s1
// and written back when s1 advances. An item marked last_gate yields one
// result, registered after s1; other items yield none. The vertex file's
// single write port and two read ports set the rate of one gate per cycle; a
// last gate behind a stalled result holds s1 and stalls the input until that
// result is taken. The user must write target and inversion through the
// config port only while the block is idle; the block does not enforce this.
// After each result a new circuit starts with no clearing pass.
// ----------------------------------------------------------------------------
module xor_and_graph_truth_table_check (
	input  logic                              clk,
	input  logic                              arst_n,
	// config port
	input  logic                              cfg_wr_en,
	input  logic [xagtc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [xagtc_pkg::CFG_DATA_W-1:0]  cfg_data,
	// gate items
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [xagtc_pkg::VIDX_W-1:0]      first_source,
	input  logic [xagtc_pkg::CODE_W-1:0]      first_code,
	input  logic [xagtc_pkg::VIDX_W-1:0]      second_source,
	input  logic [xagtc_pkg::CODE_W-1:0]      second_code,
	input  logic                              last_gate,
	// results
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              matches_res,
	output logic                              circuit_error,
	output logic [xagtc_pkg::ROWS-1:0]        final_table
);

	logic [xagtc_pkg::ROWS-1:0]   target_table_q;
	logic                         output_invert_q;
	logic [xagtc_pkg::CNT_W-1:0]  vertex_count_q;
	logic                         error_seen_q;

	logic                         accept;
	logic                         adv_s1;
	logic                         valid_s1;
	xagtc_pkg::gate_ctl_t         ctl_s1;
	xagtc_pkg::gate_ctl_t         ctl_next;
	logic [xagtc_pkg::VIDX_W-1:0] wr_addr_s1;

	logic                         src_bad_a;
	logic                         src_bad_b;
	logic                         mixed;
	logic                         full;

	logic [xagtc_pkg::ROWS-1:0]   rd_data_a;
	logic [xagtc_pkg::ROWS-1:0]   rd_data_b;
	logic [xagtc_pkg::ROWS-1:0]   gate_table;
	logic [xagtc_pkg::ROWS-1:0]   final_next;
	logic                         matches_next;

	logic                         out_valid_s2;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_table_q  <= '0;
			output_invert_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				xagtc_pkg::REG_TARGET_TABLE:  target_table_q  <= cfg_data;
				xagtc_pkg::REG_OUTPUT_INVERT: output_invert_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake: s1 drains unless it holds a last gate and the result slot is full and stalled
	assign adv_s1   = valid_s1 && (!ctl_s1.last || !out_valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;

	// gate checks at accept time
	assign src_bad_a = {1'b0, first_source} >= vertex_count_q;
	assign src_bad_b = {1'b0, second_source} >= vertex_count_q;
	assign mixed     = first_code[xagtc_pkg::CODE_KIND_BIT]
	                   != second_code[xagtc_pkg::CODE_KIND_BIT];
	assign full      = vertex_count_q == xagtc_pkg::CNT_W'(xagtc_pkg::MAX_VERTICES);

	always_comb begin
		ctl_next.first_src  = first_source;
		ctl_next.second_src = second_source;
		ctl_next.first_inv  = first_code[xagtc_pkg::CODE_INV_BIT];
		ctl_next.second_inv = second_code[xagtc_pkg::CODE_INV_BIT];
		ctl_next.first_var  = {1'b0, first_source}
		                      < xagtc_pkg::CNT_W'(xagtc_pkg::NUM_VARIABLES);
		ctl_next.second_var = {1'b0, second_source}
		                      < xagtc_pkg::CNT_W'(xagtc_pkg::NUM_VARIABLES);
		ctl_next.kind       = first_code[xagtc_pkg::CODE_KIND_BIT]
		                      ? xagtc_pkg::GATE_XOR : xagtc_pkg::GATE_AND;
		ctl_next.zero       = src_bad_a || src_bad_b || mixed;
		ctl_next.err        = error_seen_q || src_bad_a || src_bad_b || mixed || full;
		ctl_next.wr_en      = !full;
		ctl_next.last       = last_gate;
	end

	// circuit state, advanced per accepted gate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= xagtc_pkg::CNT_W'(xagtc_pkg::NUM_VARIABLES);
			error_seen_q   <= 1'b0;
		end else if (accept) begin
			if (last_gate) begin
				vertex_count_q <= xagtc_pkg::CNT_W'(xagtc_pkg::NUM_VARIABLES);
				error_seen_q   <= 1'b0;
			end else begin
				if (!full) begin
					vertex_count_q <= vertex_count_q + xagtc_pkg::CNT_W'(1);
				end
				error_seen_q <= ctl_next.err;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1     <= ctl_next;
			wr_addr_s1 <= vertex_count_q[xagtc_pkg::VIDX_W-1:0];
		end
	end

	xagtc_vstore u_vstore (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr_a (first_source),
		.rd_addr_b (second_source),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b),
		.wr_en     (adv_s1 && ctl_s1.wr_en),
		.wr_addr   (wr_addr_s1),
		.wr_data   (gate_table)
	);

	xagtc_gate_eval u_gate_eval (
		.ctl           (ctl_s1),
		.rd_data_a     (rd_data_a),
		.rd_data_b     (rd_data_b),
		.output_invert (output_invert_q),
		.target_table  (target_table_q),
		.gate_table    (gate_table),
		.final_table   (final_next),
		.table_match   (matches_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv_s1 && ctl_s1.last) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ctl_s1.last) begin
			matches_res   <= matches_next;
			circuit_error <= ctl_s1.err;
			final_table   <= final_next;
		end
	end

	assign out_valid = out_valid_s2;

endmodule

/* src/xagtc_vstore.sv */
// ----------------------------------------------------------------------------
// xagtc_vstore
// Vertex table register file: one write port, two registered read ports with
// write-through forwarding so a gate can use the gate just before it.
// ----------------------------------------------------------------------------
module xagtc_vstore (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [xagtc_pkg::VIDX_W-1:0]  rd_addr_a,
	input  logic [xagtc_pkg::VIDX_W-1:0]  rd_addr_b,
	output logic [xagtc_pkg::ROWS-1:0]    rd_data_a,
	output logic [xagtc_pkg::ROWS-1:0]    rd_data_b,
	input  logic                          wr_en,
	input  logic [xagtc_pkg::VIDX_W-1:0]  wr_addr,
	input  logic [xagtc_pkg::ROWS-1:0]    wr_data
);

	logic [xagtc_pkg::ROWS-1:0] mem [xagtc_pkg::MAX_VERTICES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
			rd_data_b <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
		end
	end

endmodule

/* src/xagtc_gate_eval.sv */
// ----------------------------------------------------------------------------
// xagtc_gate_eval
// Evaluates one gate's table from its operands and compares the final table
// against the target.
// ----------------------------------------------------------------------------
module xagtc_gate_eval (
	input  xagtc_pkg::gate_ctl_t        ctl,
	input  logic [xagtc_pkg::ROWS-1:0]  rd_data_a,
	input  logic [xagtc_pkg::ROWS-1:0]  rd_data_b,
	input  logic                        output_invert,
	input  logic [xagtc_pkg::ROWS-1:0]  target_table,
	output logic [xagtc_pkg::ROWS-1:0]  gate_table,
	output logic [xagtc_pkg::ROWS-1:0]  final_table,
	output logic                        table_match
);

	logic [xagtc_pkg::ROWS-1:0] op_a;
	logic [xagtc_pkg::ROWS-1:0] op_b;

	always_comb begin
		op_a = ctl.first_var ? xagtc_pkg::var_table(ctl.first_src) : rd_data_a;
		op_b = ctl.second_var ? xagtc_pkg::var_table(ctl.second_src) : rd_data_b;
		if (ctl.first_inv) begin
			op_a = ~op_a;
		end
		if (ctl.second_inv) begin
			op_b = ~op_b;
		end
		if (ctl.zero) begin
			gate_table = '0;
		end else if (ctl.kind == xagtc_pkg::GATE_XOR) begin
			gate_table = op_a ^ op_b;
		end else begin
			gate_table = op_a & op_b;
		end
	end

	assign final_table = output_invert ? ~gate_table : gate_table;
	assign table_match = !ctl.err && (final_table == target_table);

endmodule
